FILE: hdl/cle_pkg.sv
// Shared types and constants for the console line editor.
package cle_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int CAP_MAX      = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;
  localparam logic [8:0] CAP_LIMIT = 9'(CAP_MAX);
  localparam logic [8:0] CAP_RESET = 9'd256;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_NUL   = 8'd0;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CHAR,
    CMD_ERASE,
    CMD_EOL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic [7:0] pos;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

endpackage

FILE: hdl/cle_ifs.sv
// Channel interfaces for received bytes, echo words and configuration writes.
interface cle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic       last_of_run;
  logic       buffer_write;
  logic [7:0] write_index;
  logic [7:0] write_char;
  logic       line_done;
  logic [7:0] line_length;
  modport source (output valid, output echo_byte, output last_of_run, output buffer_write,
                  output write_index, output write_char, output line_done,
                  output line_length, input ready);
  modport sink (input valid, input echo_byte, input last_of_run, input buffer_write,
                input write_index, input write_char, input line_done,
                input line_length, output ready);
endinterface

interface cle_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] line_capacity;
  modport source (output valid, output line_capacity, input ready);
  modport sink (input valid, input line_capacity, output ready);
endinterface

FILE: hdl/cle_front.sv
// Front end: accepts received bytes, tracks the cursor and classifies each byte.
module cle_front
  import cle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cle_rx_if.sink    rx,
  cle_cfg_if.sink   cfg,
  output cmd_push_t push,
  input  logic      push_ready
);

  logic [8:0] line_capacity;
  logic [8:0] cap_eff;
  logic [7:0] cursor;
  logic [7:0] cursor_next;
  cmd_kind_t  kind;

  always_comb begin
    cap_eff = (line_capacity > CAP_LIMIT) ? CAP_LIMIT : line_capacity;
    kind = CMD_NONE;
    cursor_next = cursor;
    if (rx.rx_byte == CH_CR || rx.rx_byte == CH_LF) begin
      kind = CMD_EOL;
      cursor_next = 8'd0;
    end else if (rx.rx_byte == CH_BS || rx.rx_byte == CH_DEL) begin
      if (cursor != 8'd0) begin
        kind = CMD_ERASE;
        cursor_next = cursor - 8'd1;
      end
    end else if (rx.rx_byte >= CH_SPACE && rx.rx_byte < CH_DEL &&
                 ({1'b0, cursor} + 9'd1) < cap_eff) begin
      kind = CMD_CHAR;
      cursor_next = cursor + 8'd1;
    end
  end

  assign rx.ready       = push_ready;
  assign cfg.ready      = 1'b1;
  assign push.valid     = rx.valid && push_ready && (kind != CMD_NONE);
  assign push.cmd.kind  = kind;
  assign push.cmd.ch    = rx.rx_byte;
  assign push.cmd.pos   = cursor;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= CAP_RESET;
      cursor <= 8'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        line_capacity <= cfg.line_capacity;
      end
      if (rx.valid && rx.ready) begin
        cursor <= cursor_next;
      end
    end
  end

endmodule

FILE: hdl/cle_queue.sv
// Short command queue between the front end and the echo back end.
module cle_queue
  import cle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_push_t push,
  output logic      push_ready,
  output cmd_t      head,
  output logic      head_valid,
  input  logic      pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/cle_back.sv
// Back end: expands each command into echo words through an output register.
module cle_back
  import cle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      head_valid,
  output logic      pop,
  cle_tx_if.source  tx
);

  logic [1:0] step;
  logic       valid;
  logic [7:0] echo_byte;
  logic       last_of_run;
  logic       buffer_write;
  logic [7:0] write_index;
  logic [7:0] write_char;
  logic       line_done;
  logic [7:0] line_length;

  logic [7:0] echo_byte_next;
  logic       last_of_run_next;
  logic       buffer_write_next;
  logic [7:0] write_index_next;
  logic [7:0] write_char_next;
  logic       line_done_next;
  logic [7:0] line_length_next;
  logic       load;

  always_comb begin
    echo_byte_next    = CH_NUL;
    last_of_run_next  = 1'b1;
    buffer_write_next = 1'b0;
    write_index_next  = 8'd0;
    write_char_next   = CH_NUL;
    line_done_next    = 1'b0;
    line_length_next  = 8'd0;
    unique case (head.kind)
      CMD_CHAR: begin
        echo_byte_next    = head.ch;
        buffer_write_next = 1'b1;
        write_index_next  = head.pos;
        write_char_next   = head.ch;
      end
      CMD_ERASE: begin
        echo_byte_next   = (step == 2'd1) ? CH_SPACE : CH_BS;
        last_of_run_next = (step == 2'd2);
      end
      CMD_EOL: begin
        if (step == 2'd0) begin
          echo_byte_next    = CH_CR;
          last_of_run_next  = 1'b0;
          buffer_write_next = 1'b1;
          write_index_next  = head.pos;
          line_done_next    = 1'b1;
          line_length_next  = head.pos;
        end else begin
          echo_byte_next = CH_LF;
        end
      end
      default: begin
        last_of_run_next = 1'b1;
      end
    endcase
  end

  assign load = !valid || tx.ready;
  assign pop  = load && head_valid && last_of_run_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      step <= 2'd0;
    end else if (load) begin
      valid <= head_valid;
      if (head_valid) begin
        step <= last_of_run_next ? 2'd0 : step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      echo_byte    <= echo_byte_next;
      last_of_run  <= last_of_run_next;
      buffer_write <= buffer_write_next;
      write_index  <= write_index_next;
      write_char   <= write_char_next;
      line_done    <= line_done_next;
      line_length  <= line_length_next;
    end
  end

  assign tx.valid        = valid;
  assign tx.echo_byte    = echo_byte;
  assign tx.last_of_run  = last_of_run;
  assign tx.buffer_write = buffer_write;
  assign tx.write_index  = write_index;
  assign tx.write_char   = write_char;
  assign tx.line_done    = line_done;
  assign tx.line_length  = line_length;

endmodule

FILE: hdl/console_line_editor.sv
// Top level of the console line editor.
// Received bytes enter on rx and are taken one per cycle while the two-entry
// command queue has room; the cursor is updated as each byte is accepted, and
// bytes that cause no echo are consumed without entering the queue. The back
// end sends one echo word per cycle from its output register while tx is
// ready, so a printable byte gives one echo word, a line end two and an erase
// three; sustained throughput is set by that output stage. Configuration
// writes on cfg are always taken and set the line capacity for bytes accepted
// afterwards.
module console_line_editor
  import cle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cle_rx_if.sink    rx,
  cle_tx_if.source  tx,
  cle_cfg_if.sink   cfg
);

  cmd_push_t push;
  logic      push_ready;
  cmd_t      head;
  logic      head_valid;
  logic      pop;

  cle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .push       (push),
    .push_ready (push_ready)
  );

  cle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  cle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .tx         (tx)
  );

endmodule

FILE: hdl/cle_checker.sv
// Port-level checks for the console line editor and their binding.
module cle_checker (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] echo_byte,
  input logic       last_of_run,
  input logic       buffer_write,
  input logic [7:0] write_index,
  input logic [7:0] write_char,
  input logic       line_done,
  input logic [7:0] line_length
);

  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(echo_byte) && $stable(last_of_run))
    else $error("echo word dropped or changed while stalled");

  a_line_end: assert property (@(posedge clk) disable iff (rst)
    tx_valid && line_done |->
      buffer_write && write_char == 8'd0 && echo_byte == 8'd13 && !last_of_run &&
      line_length == write_index)
    else $error("line end word malformed");

  a_char_word: assert property (@(posedge clk) disable iff (rst)
    tx_valid && buffer_write && !line_done |-> last_of_run && write_char == echo_byte)
    else $error("stored character does not match echo");

  a_no_write: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !buffer_write |->
      write_index == 8'd0 && write_char == 8'd0 && !line_done && line_length == 8'd0)
    else $error("write fields set without buffer write");

endmodule

bind console_line_editor cle_checker u_cle_checker (
  .clk          (clk),
  .rst          (rst),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .echo_byte    (tx.echo_byte),
  .last_of_run  (tx.last_of_run),
  .buffer_write (tx.buffer_write),
  .write_index  (tx.write_index),
  .write_char   (tx.write_char),
  .line_done    (tx.line_done),
  .line_length  (tx.line_length)
);
